>>> rtl/trrw_pkg.sv
// shared constants and register codes for the tcp receive reorder window
`timescale 1ns / 1ps

package trrw_pkg;

    // field widths
    localparam int SEQ_W      = 32;
    localparam int MSS_W      = 16;
    localparam int WSEG_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int DRAIN_W    = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // default bitmap depth
    localparam int WINDOW_SLOTS_DEF = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SEGMENTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQUENCE  = 2'd2;

    // configuration reset values
    localparam logic [MSS_W-1:0]  MSS_RESET   = 16'd1460;
    localparam logic [WSEG_W-1:0] WSEG_RESET  = 7'd64;
    localparam logic [SEQ_W-1:0]  START_RESET = 32'd0;

    // segment status codes
    localparam logic [STATUS_W-1:0] SEG_IN_ORDER = 2'd0;
    localparam logic [STATUS_W-1:0] SEG_BUFFERED = 2'd1;
    localparam logic [STATUS_W-1:0] SEG_OLD      = 2'd2;
    localparam logic [STATUS_W-1:0] SEG_BEYOND   = 2'd3;

endpackage

>>> rtl/trrw_slot_divider.sv
// front part: accepts a segment and computes its bitmap slot by serial division
`timescale 1ns / 1ps

module trrw_slot_divider #(
    parameter int WINDOW_SLOTS = trrw_pkg::WINDOW_SLOTS_DEF,
    localparam int SLOT_W = $clog2(WINDOW_SLOTS),
    localparam int WIN_W  = $clog2(WINDOW_SLOTS + 1),
    localparam int ITEM_W = trrw_pkg::SEQ_W + SLOT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [trrw_pkg::SEQ_W-1:0]   segment_sequence,
    input  logic                         clearing,
    input  logic [trrw_pkg::MSS_W-1:0]   mss,
    input  logic [WIN_W-1:0]             win,
    output logic                         q_push,
    output logic [ITEM_W-1:0]            q_data,
    input  logic                         q_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIVIDE,
        F_PUSH
    } front_state_t;

    localparam int STEP_W = $clog2(trrw_pkg::SEQ_W);

    front_state_t                   state_reg;
    logic [trrw_pkg::SEQ_W-1:0]     seq_reg;
    logic [trrw_pkg::SEQ_W-1:0]     dividend_reg;
    logic [trrw_pkg::MSS_W-1:0]     rem_reg;
    logic [SLOT_W-1:0]              rmod_reg;
    logic [STEP_W-1:0]              step_reg;

    logic [trrw_pkg::MSS_W:0]       rem_shift;
    logic                           q_bit;
    logic [trrw_pkg::MSS_W-1:0]     rem_next;
    logic [SLOT_W:0]                rmod_shift;
    logic [SLOT_W-1:0]              rmod_next;
    logic                           accept;

    // one quotient bit per cycle, quotient reduced modulo the window on the fly
    always_comb
    begin
        rem_shift = {rem_reg, dividend_reg[trrw_pkg::SEQ_W-1]};
        q_bit     = rem_shift >= {1'b0, mss};
        if (q_bit)
        begin
            rem_next = trrw_pkg::MSS_W'(rem_shift - {1'b0, mss});
        end
        else
        begin
            rem_next = rem_shift[trrw_pkg::MSS_W-1:0];
        end
        rmod_shift = {rmod_reg, q_bit};
        if (rmod_shift >= (SLOT_W + 1)'(win))
        begin
            rmod_next = SLOT_W'(rmod_shift - (SLOT_W + 1)'(win));
        end
        else
        begin
            rmod_next = rmod_shift[SLOT_W-1:0];
        end
    end

    // handshake toward the input and the queue
    assign full   = (state_reg != F_IDLE) || clearing;
    assign accept = push && !full;
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = {seq_reg, rmod_reg};

    // front sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        seq_reg      <= segment_sequence;
                        dividend_reg <= segment_sequence;
                        rem_reg      <= '0;
                        rmod_reg     <= '0;
                        step_reg     <= '0;
                        state_reg    <= F_DIVIDE;
                    end
                end
                F_DIVIDE:
                begin
                    rem_reg      <= rem_next;
                    rmod_reg     <= rmod_next;
                    dividend_reg <= {dividend_reg[trrw_pkg::SEQ_W-2:0], 1'b0};
                    step_reg     <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(trrw_pkg::SEQ_W - 1))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/trrw_queue.sv
// two-entry queue between the slot divider and the window engine
`timescale 1ns / 1ps

module trrw_queue #(
    parameter int DATA_W = trrw_pkg::SEQ_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    logic              do_wr;
    logic              do_rd;

    assign q_full  = count_reg == 2'd2;
    assign q_empty = count_reg == 2'd0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/trrw_engine.sv
// back part: classifies segments against the expected number, keeps the bitmap, drains
`timescale 1ns / 1ps

module trrw_engine #(
    parameter int WINDOW_SLOTS = trrw_pkg::WINDOW_SLOTS_DEF,
    localparam int SLOT_W = $clog2(WINDOW_SLOTS),
    localparam int WIN_W  = $clog2(WINDOW_SLOTS + 1),
    localparam int ITEM_W = trrw_pkg::SEQ_W + SLOT_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  logic [ITEM_W-1:0]               q_data,
    output logic                            q_pop,
    input  logic [trrw_pkg::MSS_W-1:0]      mss,
    input  logic [WIN_W-1:0]                win,
    input  logic [trrw_pkg::SEQ_W-1:0]      limit,
    input  logic                            start_we,
    input  logic [trrw_pkg::SEQ_W-1:0]      start_value,
    output logic                            clearing,
    input  logic                            pop,
    output logic                            empty,
    output logic [trrw_pkg::SEQ_W-1:0]      ack_number,
    output logic [trrw_pkg::STATUS_W-1:0]   segment_status,
    output logic [trrw_pkg::DRAIN_W-1:0]    drained_count
);

    typedef enum logic [2:0] {
        E_CLEAR,
        E_IDLE,
        E_DRAIN_RD,
        E_DRAIN_CHK,
        E_FINISH
    } engine_state_t;

    engine_state_t                   state_reg;
    logic [trrw_pkg::SEQ_W-1:0]      expected_reg;
    logic [SLOT_W-1:0]               cur_slot_reg;
    logic [SLOT_W-1:0]               clear_cnt_reg;
    logic [WIN_W-1:0]                drained_reg;
    logic [trrw_pkg::STATUS_W-1:0]   status_reg;
    logic                            empty_reg;
    logic [trrw_pkg::SEQ_W-1:0]      ack_reg;
    logic [trrw_pkg::STATUS_W-1:0]   seg_status_reg;
    logic [trrw_pkg::DRAIN_W-1:0]    drained_out_reg;
    logic                            rd_bit_reg;

    // slot bitmap memory
    logic                            slot_mem [WINDOW_SLOTS];
    logic                            mem_we;
    logic [SLOT_W-1:0]               mem_waddr;
    logic                            mem_wdata;

    logic [trrw_pkg::SEQ_W-1:0]      head_seq;
    logic [SLOT_W-1:0]               head_slot;
    logic [trrw_pkg::SEQ_W-1:0]      seq_dist;
    logic                            ahead;
    logic                            beyond;
    logic [trrw_pkg::SEQ_W:0]        head_sum;
    logic [trrw_pkg::SEQ_W:0]        exp_sum;
    logic                            out_load;

    // next slot modulo the window
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [WIN_W-1:0] w);
        logic [SLOT_W:0] n;
        begin
            n = {1'b0, s} + 1'b1;
            if (n >= (SLOT_W + 1)'(w))
            begin
                next_slot = '0;
            end
            else
            begin
                next_slot = n[SLOT_W-1:0];
            end
        end
    endfunction

    // head item decode and classification
    assign head_seq  = q_data[SLOT_W +: trrw_pkg::SEQ_W];
    assign head_slot = q_data[SLOT_W-1:0];
    assign seq_dist  = head_seq - expected_reg;
    assign ahead     = !seq_dist[trrw_pkg::SEQ_W-1];
    assign beyond    = seq_dist > limit;
    assign head_sum  = {1'b0, head_seq} + (trrw_pkg::SEQ_W + 1)'(mss);
    assign exp_sum   = {1'b0, expected_reg} + (trrw_pkg::SEQ_W + 1)'(mss);

    assign q_pop    = (state_reg == E_IDLE) && !q_empty && !start_we;
    assign clearing = state_reg == E_CLEAR;
    assign out_load = (state_reg == E_FINISH) && (empty_reg || pop);

    // bitmap write port: clearing pass, buffered mark, drain release
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_slot_reg;
        mem_wdata = 1'b0;
        if (state_reg == E_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
        end
        else if (q_pop && (seq_dist != '0) && ahead && !beyond)
        begin
            mem_we    = 1'b1;
            mem_waddr = head_slot;
            mem_wdata = 1'b1;
        end
        else if ((state_reg == E_DRAIN_CHK) && rd_bit_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // bitmap storage with registered read at the drain slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_bit_reg <= slot_mem[cur_slot_reg];
    end

    // engine sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_CLEAR;
            clear_cnt_reg <= '0;
            cur_slot_reg  <= '0;
            expected_reg  <= trrw_pkg::START_RESET;
            empty_reg     <= 1'b1;
        end
        else
        begin
            // result register
            if (out_load)
            begin
                empty_reg       <= 1'b0;
                ack_reg         <= expected_reg - trrw_pkg::SEQ_W'(mss);
                seg_status_reg  <= status_reg;
                drained_out_reg <= trrw_pkg::DRAIN_W'(drained_reg);
            end
            else if (pop)
            begin
                empty_reg <= 1'b1;
            end

            if (start_we)
            begin
                // stream restart
                expected_reg  <= start_value;
                clear_cnt_reg <= '0;
                state_reg     <= E_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    E_CLEAR:
                    begin
                        clear_cnt_reg <= clear_cnt_reg + 1'b1;
                        if (clear_cnt_reg == SLOT_W'(WINDOW_SLOTS - 1))
                        begin
                            state_reg <= E_IDLE;
                        end
                    end
                    E_IDLE:
                    begin
                        if (!q_empty)
                        begin
                            drained_reg <= '0;
                            if (seq_dist == '0)
                            begin
                                status_reg   <= trrw_pkg::SEG_IN_ORDER;
                                expected_reg <= head_sum[trrw_pkg::SEQ_W-1:0];
                                cur_slot_reg <= head_sum[trrw_pkg::SEQ_W] ? '0
                                                : next_slot(head_slot, win);
                                state_reg    <= E_DRAIN_RD;
                            end
                            else if (ahead && beyond)
                            begin
                                status_reg <= trrw_pkg::SEG_BEYOND;
                                state_reg  <= E_FINISH;
                            end
                            else if (ahead)
                            begin
                                status_reg <= trrw_pkg::SEG_BUFFERED;
                                state_reg  <= E_FINISH;
                            end
                            else
                            begin
                                status_reg <= trrw_pkg::SEG_OLD;
                                state_reg  <= E_FINISH;
                            end
                        end
                    end
                    E_DRAIN_RD:
                    begin
                        if (drained_reg < win)
                        begin
                            state_reg <= E_DRAIN_CHK;
                        end
                        else
                        begin
                            state_reg <= E_FINISH;
                        end
                    end
                    E_DRAIN_CHK:
                    begin
                        if (rd_bit_reg)
                        begin
                            expected_reg <= exp_sum[trrw_pkg::SEQ_W-1:0];
                            cur_slot_reg <= exp_sum[trrw_pkg::SEQ_W] ? '0
                                            : next_slot(cur_slot_reg, win);
                            drained_reg  <= drained_reg + 1'b1;
                            state_reg    <= E_DRAIN_RD;
                        end
                        else
                        begin
                            state_reg <= E_FINISH;
                        end
                    end
                    E_FINISH:
                    begin
                        if (empty_reg || pop)
                        begin
                            state_reg <= E_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= E_IDLE;
                    end
                endcase
            end
        end
    end

    assign empty          = empty_reg;
    assign ack_number     = ack_reg;
    assign segment_status = seg_status_reg;
    assign drained_count  = drained_out_reg;

endmodule

>>> rtl/tcp_receive_reorder_window_unit.sv
// The serial slot divider computes the bitmap slot one quotient bit per cycle and takes no
// new segment until it has pushed the last one into the two-entry queue; a long drain
// backs up that queue. Reset: asynchronous, active low; after reset and after each
// start_sequence write a clearing pass runs over the bitmap, with full held high.
`timescale 1ns / 1ps

module tcp_receive_reorder_window_unit #(
    parameter int WINDOW_SLOTS = trrw_pkg::WINDOW_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // segment input queue side
    input  logic                             push,
    output logic                             full,
    input  logic [trrw_pkg::SEQ_W-1:0]       segment_sequence,
    // result queue side
    output logic                             empty,
    input  logic                             pop,
    output logic [trrw_pkg::SEQ_W-1:0]       ack_number,
    output logic [trrw_pkg::STATUS_W-1:0]    segment_status,
    output logic [trrw_pkg::DRAIN_W-1:0]     drained_count,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [trrw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trrw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int WIN_W  = $clog2(WINDOW_SLOTS + 1);
    localparam int ITEM_W = trrw_pkg::SEQ_W + SLOT_W;
    localparam int LIM_W  = WIN_W + trrw_pkg::MSS_W;

    logic [trrw_pkg::MSS_W-1:0]   mss_reg;
    logic [trrw_pkg::WSEG_W-1:0]  wseg_reg;
    logic [trrw_pkg::SEQ_W-1:0]   limit_reg;

    logic [trrw_pkg::MSS_W-1:0]   eff_mss;
    logic [WIN_W-1:0]             eff_win;
    logic [LIM_W-1:0]             limit_next;
    logic                         start_we;

    logic                         q_push;
    logic [ITEM_W-1:0]            q_wdata;
    logic                         q_full;
    logic                         q_pop;
    logic [ITEM_W-1:0]            q_rdata;
    logic                         q_empty;
    logic                         clearing;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg  <= trrw_pkg::MSS_RESET;
            wseg_reg <= trrw_pkg::WSEG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == trrw_pkg::REG_SEGMENT_SIZE)
            begin
                mss_reg <= cfg_data[trrw_pkg::MSS_W-1:0];
            end
            else if (cfg_index == trrw_pkg::REG_WINDOW_SEGMENTS)
            begin
                wseg_reg <= cfg_data[trrw_pkg::WSEG_W-1:0];
            end
        end
    end

    assign start_we = cfg_we && (cfg_index == trrw_pkg::REG_START_SEQUENCE);

    // effective segment size and window
    always_comb
    begin
        eff_mss = (mss_reg == '0) ? trrw_pkg::MSS_W'(1) : mss_reg;
        if (wseg_reg == '0)
        begin
            eff_win = WIN_W'(1);
        end
        else if (32'(wseg_reg) > 32'(WINDOW_SLOTS))
        begin
            eff_win = WIN_W'(WINDOW_SLOTS);
        end
        else
        begin
            eff_win = WIN_W'(wseg_reg);
        end
    end

    // window span in sequence units, registered
    assign limit_next = LIM_W'(eff_win - 1'b1) * LIM_W'(eff_mss);

    always_ff @(posedge clk)
    begin
        limit_reg <= trrw_pkg::SEQ_W'(limit_next);
    end

    trrw_slot_divider #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_divider (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .segment_sequence (segment_sequence),
        .clearing         (clearing),
        .mss              (eff_mss),
        .win              (eff_win),
        .q_push           (q_push),
        .q_data           (q_wdata),
        .q_full           (q_full)
    );

    trrw_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    trrw_engine #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .mss            (eff_mss),
        .win            (eff_win),
        .limit          (limit_reg),
        .start_we       (start_we),
        .start_value    (cfg_data[trrw_pkg::SEQ_W-1:0]),
        .clearing       (clearing),
        .pop            (pop),
        .empty          (empty),
        .ack_number     (ack_number),
        .segment_status (segment_status),
        .drained_count  (drained_count)
    );

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the tcp receive reorder window unit
`timescale 1ns / 1ps

module tb_top;

    // index past the end of the register list, writes to it are dropped
    localparam logic [trrw_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int CFG_SETTLE = 200;  // idle cycles before a register write
    localparam int DRAIN_WAIT = 200;  // idle cycles after the last ack
    localparam int IDLE_LIMIT = 3000; // cycles with no transfer before giving up

    typedef struct packed {
        logic [trrw_pkg::SEQ_W-1:0]    ack;
        logic [trrw_pkg::STATUS_W-1:0] status;
        logic [trrw_pkg::DRAIN_W-1:0]  drained;
    } ack_result_t;

    typedef struct packed {
        logic                            is_cfg;
        logic [trrw_pkg::CFG_IDX_W-1:0]  index;
        logic [trrw_pkg::SEQ_W-1:0]      value;
    } arrival_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [trrw_pkg::SEQ_W-1:0]      segment_sequence = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [trrw_pkg::SEQ_W-1:0]      ack_number;
    logic [trrw_pkg::STATUS_W-1:0]   segment_status;
    logic [trrw_pkg::DRAIN_W-1:0]    drained_count;
    logic                            cfg_we = 1'b0;
    logic [trrw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [trrw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // segments and register writes waiting to be driven
    arrival_t    arrival_q[$];
    // acks predicted for accepted segments, oldest first
    ack_result_t pending_acks[$];

    // receiver image kept by the predictor
    logic [trrw_pkg::MSS_W-1:0]            tb_mss;
    logic [trrw_pkg::WSEG_W-1:0]           tb_wnd;
    logic [trrw_pkg::SEQ_W-1:0]            rx_next_seq;
    logic [trrw_pkg::WINDOW_SLOTS_DEF-1:0] rx_slot_map;

    // stream generator state
    logic [trrw_pkg::SEQ_W-1:0] gen_base = '0;
    int                         queued_segments = 0;

    int  fail_count = 0;
    int  feed_wait = 0;
    int  pop_wait = 0;
    int  settle_cnt = 0;
    int  idle_cnt = 0;
    bit  drv_calm = 1'b0;
    bit  mon_calm = 1'b0;

    tcp_receive_reorder_window_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .segment_sequence (segment_sequence),
        .empty            (empty),
        .pop              (pop),
        .ack_number       (ack_number),
        .segment_status   (segment_status),
        .drained_count    (drained_count),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bitmap slot of a sequence number
    function automatic int slot_index(input logic [trrw_pkg::SEQ_W-1:0] seq,
                                      input logic [31:0] mss, input logic [31:0] wnd);
        return int'((seq / mss) % wnd);
    endfunction

    // idle cycles before the next transfer on one side
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    // register write as seen by the receiver image
    task automatic apply_config(input logic [trrw_pkg::CFG_IDX_W-1:0] idx,
                                input logic [trrw_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            trrw_pkg::REG_SEGMENT_SIZE:    tb_mss = val[trrw_pkg::MSS_W-1:0];
            trrw_pkg::REG_WINDOW_SEGMENTS: tb_wnd = val[trrw_pkg::WSEG_W-1:0];
            trrw_pkg::REG_START_SEQUENCE:
            begin
                // stream restart
                rx_next_seq = val[trrw_pkg::SEQ_W-1:0];
                rx_slot_map = '0;
            end
            default: ;
        endcase
    endtask

    // classify one arriving segment, update the window and queue its ack
    task automatic predict_ack(input logic [trrw_pkg::SEQ_W-1:0] seq);
        logic [31:0]                   mss;
        logic [31:0]                   wnd;
        logic [31:0]                   seq_dist;
        logic [31:0]                   drained;
        logic [trrw_pkg::STATUS_W-1:0] status;
        ack_result_t                   res;
        mss = (tb_mss == 0) ? 32'd1 : 32'(tb_mss);
        wnd = (tb_wnd == 0) ? 32'd1 :
              (tb_wnd > trrw_pkg::WINDOW_SLOTS_DEF) ? 32'(trrw_pkg::WINDOW_SLOTS_DEF)
                                                    : 32'(tb_wnd);
        seq_dist = seq - rx_next_seq;
        drained = 0;
        if (seq_dist == 0)
        begin
            // in order: advance, then release consecutive buffered slots
            status = trrw_pkg::SEG_IN_ORDER;
            rx_next_seq = rx_next_seq + mss;
            while (drained < wnd && rx_slot_map[slot_index(rx_next_seq, mss, wnd)])
            begin
                rx_slot_map[slot_index(rx_next_seq, mss, wnd)] = 1'b0;
                rx_next_seq = rx_next_seq + mss;
                drained = drained + 1;
            end
        end
        else if (!seq_dist[31])
        begin
            if (seq_dist > (wnd - 1) * mss)
                status = trrw_pkg::SEG_BEYOND;
            else
            begin
                status = trrw_pkg::SEG_BUFFERED;
                rx_slot_map[slot_index(seq, mss, wnd)] = 1'b1;
            end
        end
        else
            status = trrw_pkg::SEG_OLD;
        res.ack     = rx_next_seq - mss;
        res.status  = status;
        res.drained = drained[trrw_pkg::DRAIN_W-1:0];
        pending_acks.push_back(res);
    endtask

    task automatic add_seg(input logic [trrw_pkg::SEQ_W-1:0] seq);
        arrival_t a;
        a.is_cfg = 1'b0;
        a.index  = '0;
        a.value  = seq;
        arrival_q.push_back(a);
        queued_segments++;
    endtask

    task automatic add_cfg(input logic [trrw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [trrw_pkg::CFG_DATA_W-1:0] val);
        arrival_t a;
        a.is_cfg = 1'b1;
        a.index  = idx;
        a.value  = val;
        arrival_q.push_back(a);
    endtask

    // configure, then send a reordered stream of whole windows with some loss and noise
    task automatic queue_phase(input logic [trrw_pkg::MSS_W-1:0] mss,
                               input logic [trrw_pkg::WSEG_W-1:0] wnd,
                               input bit restart, input logic [trrw_pkg::SEQ_W-1:0] start,
                               input int n_items);
        logic [31:0] m;
        logic [31:0] w;
        int          order[trrw_pkg::WINDOW_SLOTS_DEF];
        int          drop_q[$];
        int          target;
        int          k;
        int          i;
        int          span;
        int          chunk_end;
        int          pick;
        int          tmp;
        int          r;
        m = (mss == 0) ? 32'd1 : 32'(mss);
        w = (wnd == 0) ? 32'd1 :
            (wnd > trrw_pkg::WINDOW_SLOTS_DEF) ? 32'(trrw_pkg::WINDOW_SLOTS_DEF) : 32'(wnd);
        add_cfg(trrw_pkg::REG_SEGMENT_SIZE, ($urandom & 32'hFFFF_0000) | 32'(mss));
        add_cfg(trrw_pkg::REG_WINDOW_SEGMENTS, ($urandom & 32'hFFFF_FF80) | 32'(wnd));
        if (restart)
        begin
            add_cfg(trrw_pkg::REG_START_SEQUENCE, start);
            gen_base = start;
        end
        if ($urandom_range(0, 1) == 1)
            add_cfg(REG_UNUSED, $urandom);
        target = queued_segments + n_items;
        k = 0;
        while (queued_segments < target)
        begin
            // shuffle within chunks of random span, span of one keeps order
            for (i = 0; i < w; i++)
                order[i] = i;
            span = $urandom_range(1, w);
            for (i = 0; i < w; i++)
            begin
                chunk_end = ((i / span) + 1) * span - 1;
                if (chunk_end > w - 1)
                    chunk_end = w - 1;
                pick = $urandom_range(i, chunk_end);
                tmp = order[i];
                order[i] = order[pick];
                order[pick] = tmp;
            end
            drop_q = {};
            for (i = 0; i < w; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    drop_q.push_back(order[i]);
                else
                    add_seg(gen_base + (k + order[i]) * m);
                // noise: duplicates, unaligned, far ahead, anything
                if (r >= 90 && r <= 92)
                    add_seg(gen_base + k * m - $urandom_range(0, w) * m);
                else if (r >= 93 && r <= 95)
                    add_seg(gen_base + k * m + $urandom_range(0, w * m - 1));
                else if (r >= 96 && r <= 97)
                    add_seg(gen_base + (k + 2 * w + $urandom_range(0, w)) * m);
                else if (r >= 98)
                    add_seg($urandom);
            end
            // retransmit lost segments
            foreach (drop_q[j])
                add_seg(gen_base + (k + drop_q[j]) * m);
            k += w;
        end
        gen_base = gen_base + k * m;
    endtask

    // calm stretches with no idling on either side
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            drv_calm <= !drv_calm;
        if ($urandom_range(0, 299) == 0)
            mon_calm <= !mon_calm;
    end

    // segment and register driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push        <= 1'b0;
            cfg_we      <= 1'b0;
            feed_wait   = 0;
            settle_cnt  = 0;
            tb_mss      = trrw_pkg::MSS_RESET;
            tb_wnd      = trrw_pkg::WSEG_RESET;
            rx_next_seq = trrw_pkg::START_RESET;
            rx_slot_map = '0;
        end
        else
        begin
            // transfers at this edge
            if (cfg_we)
                apply_config(cfg_index, cfg_data);
            if (push && !full)
            begin
                predict_ack(segment_sequence);
                feed_wait = draw_wait(drv_calm);
            end
            if (pending_acks.size() == 0 && !push)
                settle_cnt++;
            else
                settle_cnt = 0;

            if (push && full)
            begin
                // hold the offered segment
            end
            else if (feed_wait != 0)
            begin
                feed_wait--;
                push   <= 1'b0;
                cfg_we <= 1'b0;
            end
            else if (arrival_q.size() == 0)
            begin
                push   <= 1'b0;
                cfg_we <= 1'b0;
            end
            else if (arrival_q[0].is_cfg)
            begin
                // register writes only once every ack is back
                push <= 1'b0;
                if (settle_cnt >= CFG_SETTLE)
                begin
                    cfg_we    <= 1'b1;
                    cfg_index <= arrival_q[0].index;
                    cfg_data  <= arrival_q[0].value;
                    void'(arrival_q.pop_front());
                end
                else
                    cfg_we <= 1'b0;
            end
            else
            begin
                push             <= 1'b1;
                segment_sequence <= arrival_q[0].value;
                cfg_we           <= 1'b0;
                void'(arrival_q.pop_front());
            end
        end
    end

    // ack monitor and checker
    always @(posedge clk)
    begin
        ack_result_t want;
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_wait = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_acks.size() == 0)
                begin
                    $display("%0t: unexpected ack transfer, ack_number %h status %0d drained %0d",
                             $time, ack_number, segment_status, drained_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_acks.pop_front();
                    if (ack_number !== want.ack)
                    begin
                        $display("%0t: ack_number expected %h, got %h",
                                 $time, want.ack, ack_number);
                        fail_count++;
                    end
                    if (segment_status !== want.status)
                    begin
                        $display("%0t: segment_status expected %0d, got %0d",
                                 $time, want.status, segment_status);
                        fail_count++;
                    end
                    if (drained_count !== want.drained)
                    begin
                        $display("%0t: drained_count expected %0d, got %0d",
                                 $time, want.drained, drained_count);
                        fail_count++;
                    end
                end
                pop_wait = draw_wait(mon_calm);
            end
            if (pop_wait != 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cnt);
                $display("** tcp_receive_reorder_window_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        // reset defaults: basic in order, reorder drain, old, window edge
        add_seg(32'd0);
        add_seg(32'd2920);
        add_seg(32'd4380);
        add_seg(32'd1460);
        add_seg(32'd0);
        add_seg(32'd5840 + 32'd63 * 32'd1460);
        add_seg(32'd5840 + 32'd63 * 32'd1460 + 32'd1);
        add_seg(32'd5840 + 32'h7FFF_FFFF);
        add_seg(32'd5840 + 32'h8000_0000);
        add_seg(32'hFFFF_FFFF);

        // every slot marked, drain stops at the window
        add_cfg(trrw_pkg::REG_SEGMENT_SIZE, 32'hABCD_000A);
        add_cfg(trrw_pkg::REG_WINDOW_SEGMENTS, 32'd4);
        add_cfg(trrw_pkg::REG_START_SEQUENCE, 32'd0);
        add_seg(32'd10);
        add_seg(32'd20);
        add_seg(32'd30);
        add_seg(32'd5);
        add_seg(32'd0);

        // zero size and zero window, sequence wrap
        add_cfg(trrw_pkg::REG_SEGMENT_SIZE, 32'hFFFF_0000);
        add_cfg(trrw_pkg::REG_WINDOW_SEGMENTS, 32'h0000_0080);
        add_cfg(trrw_pkg::REG_START_SEQUENCE, 32'hFFFF_FFFF);
        add_seg(32'hFFFF_FFFF);
        add_seg(32'd1);
        add_seg(32'd0);

        // window shrink keeps the bitmap, stale slot gets drained
        add_cfg(trrw_pkg::REG_SEGMENT_SIZE, 32'd100);
        add_cfg(trrw_pkg::REG_WINDOW_SEGMENTS, 32'd16);
        add_cfg(trrw_pkg::REG_START_SEQUENCE, 32'd1000);
        add_seg(32'd1900);
        add_cfg(trrw_pkg::REG_WINDOW_SEGMENTS, 32'hFFFF_FF88);
        add_cfg(REG_UNUSED, $urandom);
        add_seg(32'd1000);
        add_seg(32'd1100);

        // random streams over several settings
        queue_phase(16'd1460, 7'd64, 1'b1, $urandom, 130);
        queue_phase(16'd1, 7'd1, 1'b1, 32'd0, 100);
        queue_phase(16'd65535, 7'd127, 1'b1, 32'hFFFF_0000, 130);
        queue_phase(16'd0, 7'd5, 1'b1, $urandom, 110);
        queue_phase(16'd536, 7'd64, 1'b1, $urandom, 130);
        queue_phase(16'd536, 7'd12, 1'b0, 32'd0, 110);
        queue_phase(16'($urandom_range(1, 65535)), 7'($urandom_range(1, 64)), 1'b1,
                    $urandom, 120);
        queue_phase(16'($urandom_range(1, 300)), 7'($urandom_range(2, 16)), 1'b1,
                    $urandom, 120);
        queue_phase(16'd1, 7'd64, 1'b1, 32'hFFFF_FFC0, 130);
        queue_phase(16'd2, 7'd3, 1'b1, $urandom, 100);
        queue_phase(16'($urandom_range(1, 65535)), 7'($urandom_range(65, 127)), 1'b1,
                    $urandom, 120);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the feed to run dry and every ack to come back
        while (arrival_q.size() != 0 || push || cfg_we)
            @(posedge clk);
        while (pending_acks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("** tcp_receive_reorder_window_unit: PASSED **");
        else
            $display("** tcp_receive_reorder_window_unit: FAILED **");
        $finish;
    end

endmodule
